@@ sv/dfa_word_acceptor_assert.svh @@
`ifndef DFA_WORD_ACCEPTOR_ASSERT_SVH
`define DFA_WORD_ACCEPTOR_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define DWA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfa_word_acceptor assertion failed");

// next-cycle implication, checked while out of reset
`define DWA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfa_word_acceptor assertion failed");

`endif

@@ sv/dwa_pkg.sv @@
package dwa_pkg;

  localparam int NUM_STATES_DEF  = 16;
  localparam int NUM_LETTERS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int LIM_W           = 9;
  localparam int SLIM_W          = 7;

  localparam logic [4:0] ALPHA_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_LETTER = 2'd1,
    REQ_FINISH = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CFG_INIT  = 2'd0,
    CFG_MASK  = 2'd1,
    CFG_ALPHA = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_STEP,
    OP_BAD,
    OP_FINISH
  } op_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] entry_state;
    logic [3:0] entry_letter;
    logic [3:0] entry_next;
    logic [3:0] letter;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] end_state;
    logic       bad_letter;
  } out_t;

  typedef struct packed {
    logic [3:0]  init_state;
    logic [15:0] accept_mask;
    logic [4:0]  alphabet_size;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic [3:0] st;
    logic [3:0] lt;
    logic [3:0] nxt;
  } mid_item_t;

endpackage

@@ sv/dfa_word_acceptor.sv @@
// Table-driven DFA word matcher. Load words fill the next-state table, letter words step the
// current state one table read each, and a finish word queues one result (accepted, end state,
// bad-letter flag) and rearms the next word on the initial state. One word is taken per clock
// cycle, letters included, unless the input queue is full: the table read data register feeds
// straight back into the next read address. A finish word is registered in the input queue,
// then in the result queue, before it shows up on the result ports. Two-entry queues
// sit between the input and the execution stage and in front of the result ports, so either
// side may stall on its own.
// Table entries are undefined until loaded, and there is no clearing pass after reset.
module dfa_word_acceptor import dwa_pkg::*; #(
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int NUM_LETTERS = NUM_LETTERS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_t                   req_i,
  output logic                  empty,
  input  logic                  pop,
  output out_t                  rsp_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RW = $bits(out_t);

  cfg_t          cfg_q;
  logic          mid_valid, mid_pop;
  mid_item_t     mid_item;
  logic          res_full, res_push;
  out_t          res;
  logic [RW-1:0] rsp_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_state    <= '0;
      cfg_q.accept_mask   <= '0;
      cfg_q.alphabet_size <= ALPHA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INIT:  cfg_q.init_state    <= cfg_data_i[3:0];
        CFG_MASK:  cfg_q.accept_mask   <= cfg_data_i[15:0];
        CFG_ALPHA: cfg_q.alphabet_size <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  dwa_front #(
    .NUM_STATES  (NUM_STATES),
    .NUM_LETTERS (NUM_LETTERS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req_i),
    .full_o      (full),
    .cfg_i       (cfg_q),
    .mid_valid_o (mid_valid),
    .mid_item_o  (mid_item),
    .mid_pop_i   (mid_pop)
  );

  dwa_back #(
    .NUM_STATES  (NUM_STATES),
    .NUM_LETTERS (NUM_LETTERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_valid_i (mid_valid),
    .mid_item_i  (mid_item),
    .mid_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  dwa_fifo #(
    .DATA_W (RW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (rsp_data),
    .empty_o (empty)
  );

  assign rsp_o = out_t'(rsp_data);

endmodule

@@ sv/dwa_fifo.sv @@
module dwa_fifo import dwa_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] store_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/dwa_front.sv @@
module dwa_front import dwa_pkg::*; #(
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int NUM_LETTERS = NUM_LETTERS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_t       req_i,
  output logic      full_o,
  input  cfg_t      cfg_i,
  output logic      mid_valid_o,
  output mid_item_t mid_item_o,
  input  logic      mid_pop_i
);

  localparam int MW = $bits(mid_item_t);

  mid_item_t      item;
  logic           enq;
  logic           mid_empty;
  logic [MW-1:0]  mid_data;

  always_comb begin
    item     = '0;
    item.st  = req_i.entry_state;
    item.nxt = req_i.entry_next;
    enq      = 1'b0;
    case (req_e'(req_i.req_type))
      REQ_LOAD: begin
        item.op = OP_LOAD;
        item.lt = req_i.entry_letter;
        enq     = (SLIM_W'(req_i.entry_state) < SLIM_W'(NUM_STATES)) &&
                  (LIM_W'(req_i.entry_letter) < LIM_W'(NUM_LETTERS));
      end
      REQ_LETTER: begin
        item.lt = req_i.letter;
        item.op = ((LIM_W'(req_i.letter) < LIM_W'(cfg_i.alphabet_size)) &&
                   (LIM_W'(req_i.letter) < LIM_W'(NUM_LETTERS))) ? OP_STEP : OP_BAD;
        enq     = 1'b1;
      end
      REQ_FINISH: begin
        item.op = OP_FINISH;
        enq     = 1'b1;
      end
      default: begin
        enq = 1'b0;
      end
    endcase
  end

  dwa_fifo #(
    .DATA_W (MW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && enq),
    .data_i  (item),
    .full_o  (full_o),
    .pop_i   (mid_pop_i),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign mid_valid_o = !mid_empty;
  assign mid_item_o  = mid_item_t'(mid_data);

endmodule

@@ sv/dwa_back.sv @@
module dwa_back import dwa_pkg::*; #(
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int NUM_LETTERS = NUM_LETTERS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      mid_valid_i,
  input  mid_item_t mid_item_i,
  output logic      mid_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_t      res_o
);

  localparam int TBL_DEPTH = NUM_STATES * NUM_LETTERS;
  localparam int AW        = $clog2((TBL_DEPTH > 1) ? TBL_DEPTH : 2);

  logic [3:0]    tbl_mem [TBL_DEPTH];
  logic [3:0]    rdata_q;
  logic [3:0]    cur_q, cur_d;
  logic          from_mem_q, from_mem_d;
  logic          in_word_q, in_word_d;
  logic          err_q, err_d;
  logic [3:0]    eff, base;
  logic          base_err, base_ok;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;

  assign eff      = from_mem_q ? rdata_q : cur_q;
  assign base     = in_word_q ? eff : cfg_i.init_state;
  assign base_err = in_word_q && err_q;
  assign base_ok  = SLIM_W'(base) < SLIM_W'(NUM_STATES);

  assign rd_addr = AW'(32'(base) * 32'(NUM_LETTERS) + 32'(mid_item_i.lt));
  assign wr_addr = AW'(32'(mid_item_i.st) * 32'(NUM_LETTERS) + 32'(mid_item_i.lt));

  always_comb begin
    mid_pop_o  = 1'b0;
    res_push_o = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    cur_d      = eff;
    from_mem_d = 1'b0;
    in_word_d  = in_word_q;
    err_d      = err_q;
    res_o.accepted   = !base_err && cfg_i.accept_mask[base];
    res_o.end_state  = base;
    res_o.bad_letter = base_err;
    if (mid_valid_i) begin
      case (mid_item_i.op)
        OP_LOAD: begin
          mid_pop_o = 1'b1;
          wr_en     = 1'b1;
        end
        OP_STEP: begin
          mid_pop_o  = 1'b1;
          cur_d      = base;
          in_word_d  = 1'b1;
          err_d      = base_err;
          rd_en      = base_ok;
          from_mem_d = base_ok;
        end
        OP_BAD: begin
          mid_pop_o = 1'b1;
          cur_d     = base;
          in_word_d = 1'b1;
          err_d     = 1'b1;
        end
        OP_FINISH: begin
          if (!res_full_i) begin
            mid_pop_o  = 1'b1;
            res_push_o = 1'b1;
            cur_d      = base;
            in_word_d  = 1'b0;
          end
        end
        default: begin
          mid_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      from_mem_q <= 1'b0;
      in_word_q  <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      cur_q      <= cur_d;
      from_mem_q <= from_mem_d;
      in_word_q  <= in_word_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= mid_item_i.nxt;
    end
    if (rd_en) begin
      rdata_q <= tbl_mem[rd_addr];
    end
  end

endmodule

@@ sv/dwa_checker.sv @@
`include "dfa_word_acceptor_assert.svh"

module dwa_checker import dwa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic full,
  input logic empty,
  input logic pop,
  input out_t rsp_o
);

  `DWA_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(rsp_o))
  `DWA_ASSERT_IMP(a_bad_rejects, clk_i, rst_ni, !empty && rsp_o.bad_letter, !rsp_o.accepted)
  `DWA_ASSERT_IMP(a_reset_idle, clk_i, rst_ni, $rose(rst_ni), empty && !full)

endmodule

bind dfa_word_acceptor dwa_checker u_dwa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .rsp_o  (rsp_o)
);

@@ tb/tb_dfa_word_acceptor.sv @@
module tb_dfa_word_acceptor;
  import dwa_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int IN_W = $bits(in_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t req_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_t rsp_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  in_t pending_q[$];
  out_t verdict_q[$];
  int err_cnt = 0;
  int unsigned send_idle = 31;
  int unsigned recv_idle = 83;
  logic hold_kick = 1'b0;
  int hold_left = 0;

  logic [3:0] nst_tbl[NUM_STATES_DEF][NUM_LETTERS_DEF];
  logic [3:0] cur_st = '0;
  logic in_wd = 1'b0;
  logic bad_seen = 1'b0;
  logic [3:0] m_init = '0;
  logic [15:0] m_mask = '0;
  logic [4:0] m_alpha = ALPHA_RESET;

  dfa_word_acceptor dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .req_i(req_i),
    .empty(empty),
    .pop(pop),
    .rsp_o(rsp_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int letter_limit();
    return (m_alpha > NUM_LETTERS_DEF) ? NUM_LETTERS_DEF : int'(m_alpha);
  endfunction

  function automatic void dfa_step(in_t w);
    out_t r;
    if (w.req_type == REQ_LETTER || w.req_type == REQ_FINISH) begin
      if (!in_wd) begin
        cur_st = m_init;
        bad_seen = 1'b0;
        in_wd = 1'b1;
      end
    end
    case (w.req_type)
      REQ_LOAD: begin
        nst_tbl[w.entry_state][w.entry_letter] = w.entry_next;
      end
      REQ_LETTER: begin
        if (int'(w.letter) >= letter_limit()) bad_seen = 1'b1;
        else cur_st = nst_tbl[cur_st][w.letter];
      end
      REQ_FINISH: begin
        r.accepted = !bad_seen && m_mask[cur_st];
        r.end_state = cur_st;
        r.bad_letter = bad_seen;
        verdict_q.insert(verdict_q.size(), r);
        in_wd = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_verdict(out_t got);
    out_t want;
    if (verdict_q.size() == 0) begin
      $error("unexpected result %p", got);
      err_cnt++;
      return;
    end
    want = verdict_q.pop_front();
    if (got.accepted !== want.accepted) begin
      $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
      err_cnt++;
    end
    if (got.end_state !== want.end_state) begin
      $error("end_state: expected %0d, got %0d", want.end_state, got.end_state);
      err_cnt++;
    end
    if (got.bad_letter !== want.bad_letter) begin
      $error("bad_letter: expected %0d, got %0d", want.bad_letter, got.bad_letter);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      req_i <= '0;
    end else begin
      if (push && !full) dfa_step(req_i);
      if (!push || !full) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          push <= 1'b1;
          req_i <= pending_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_verdict(rsp_o);
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic in_t rand_word(logic [1:0] kind);
    logic [IN_W-1:0] raw;
    in_t w;
    raw = IN_W'($urandom);
    w = raw;
    w.req_type = kind;
    return w;
  endfunction

  function automatic void add_word(in_t w);
    pending_q.insert(pending_q.size(), w);
  endfunction

  function automatic void add_load(logic [3:0] s, logic [3:0] l, logic [3:0] n);
    in_t w;
    w = rand_word(REQ_LOAD);
    w.entry_state = s;
    w.entry_letter = l;
    w.entry_next = n;
    add_word(w);
  endfunction

  function automatic void add_letter(logic [3:0] l);
    in_t w;
    w = rand_word(REQ_LETTER);
    w.letter = l;
    add_word(w);
  endfunction

  function automatic void add_finish();
    add_word(rand_word(REQ_FINISH));
  endfunction

  task automatic drain();
    do @(negedge clk_i); while (pending_q.size() != 0 || push || verdict_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
  endtask

  task automatic set_config(logic [3:0] init, logic [15:0] mask, logic [4:0] alpha);
    logic [15:0] d;
    drain();
    d = 16'($urandom);
    d[3:0] = init;
    write_reg(CFG_INIT, d);
    write_reg(CFG_MASK, mask);
    d = 16'($urandom);
    d[4:0] = alpha;
    write_reg(CFG_ALPHA, d);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_init = init;
    m_mask = mask;
    m_alpha = alpha;
    @(negedge clk_i);
  endtask

  task automatic gen_random(int n);
    int made;
    int len;
    int lim;
    in_t w;
    made = 0;
    lim = letter_limit();
    while (made < n) begin
      case ($urandom_range(19))
        0, 1: begin
          add_word(rand_word(REQ_LOAD));
          made++;
        end
        2: add_word(rand_word(REQ_NONE));
        default: begin
          len = $urandom_range(9);
          repeat (len) begin
            w = rand_word(REQ_LETTER);
            if (lim != 0 && $urandom_range(9) != 0) w.letter = 4'($urandom_range(lim - 1));
            add_word(w);
            made++;
            case ($urandom_range(24))
              0: add_word(rand_word(REQ_NONE));
              1: begin
                add_word(rand_word(REQ_LOAD));
                made++;
              end
              default: ;
            endcase
          end
          add_finish();
          made++;
        end
      endcase
    end
  endtask

  initial begin
    #2000000;
    $display("FAIL dfa_word_acceptor");
    $finish;
  end

  initial begin
    in_t w;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // load every table entry so no letter ever reads an unwritten one
    for (int s = 0; s < NUM_STATES_DEF; s++) begin
      for (int l = 0; l < NUM_LETTERS_DEF; l++) add_load(4'(s), 4'(l), 4'($urandom));
    end
    add_finish();
    add_letter(4'd0);
    add_letter(4'd15);
    add_finish();
    w = '1;
    add_word(w);
    add_finish();
    add_load(4'd15, 4'd15, 4'd0);
    add_load(4'd0, 4'd0, 4'd15);
    add_letter(4'd0);
    add_letter(4'd15);
    add_finish();

    set_config(4'd15, 16'hFFFF, 5'd1);
    add_finish();
    add_letter(4'd0);
    add_finish();
    add_letter(4'd1);
    add_letter(4'd0);
    add_finish();
    add_letter(4'd15);
    add_finish();

    set_config(4'd0, 16'h8001, 5'd0);
    add_letter(4'd0);
    add_finish();
    add_finish();

    set_config(4'd7, 16'h5555, 5'd31);
    add_letter(4'd15);
    add_letter(4'd0);
    add_finish();

    set_config(4'($urandom), 16'($urandom), 5'd16);
    gen_random(250);
    set_config(4'($urandom), 16'($urandom), 5'($urandom_range(1, 15)));
    gen_random(200);

    send_idle = 83;
    recv_idle = 31;
    set_config(4'd0, 16'h0000, 5'd16);
    gen_random(150);
    set_config(4'd15, 16'hFFFF, 5'd17);
    gen_random(150);

    send_idle = 0;
    recv_idle = 0;
    set_config(4'($urandom), 16'($urandom), 5'd16);
    gen_random(300);
    // back up the result side while words keep coming in
    hold_kick = 1'b1;
    @(negedge clk_i);
    hold_kick = 1'b0;
    set_config(4'($urandom), 16'($urandom), 5'd0);
    gen_random(50);
    set_config(4'($urandom), 16'($urandom), 5'($urandom_range(2, 16)));
    gen_random(250);

    drain();
    repeat (10) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS dfa_word_acceptor");
    end else begin
      $display("FAIL dfa_word_acceptor");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/dwa_pkg.sv
sv/dwa_fifo.sv
sv/dwa_front.sv
sv/dwa_back.sv
sv/dfa_word_acceptor.sv
sv/dwa_checker.sv
tb/tb_dfa_word_acceptor.sv
